@@ sv/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg: shared constants for the logic combine control block.
// Defaults for the lane count, value width and fraction bits, and mode codes.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int LANES_DEF       = 8;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int VALUE_WIDTH_DEF = 16;

   localparam int MODE_W  = 4;
   localparam int COUNT_W = 4;

   localparam logic [MODE_W-1:0] MODE_PASS   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_EQ     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_LT     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_LE     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_GT     = 4'd4;
   localparam logic [MODE_W-1:0] MODE_GE     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_ANY    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_ALL    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_AVG    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 4'd9;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_COUNT     = 2'd2;

endpackage

@@ sv/logic_combine_control.sv @@
// ----------------------------------------------------------------------------
// logic_combine_control
// Combines one snapshot of fixed-point sensor lanes into one control output.
// ----------------------------------------------------------------------------
// A beat is taken when the block is idle. Its result is moved into the output
// register once the work is done, and the next beat can be taken while that
// result waits on the rsp side. Compare, any, all, toggle and passthrough
// results are registered when the beat is taken. Product multiplies each lane
// into the running product one multiplier bit per cycle by a shift-add unit,
// and each lane's product is then shifted and clamped in a fix step. Average
// adds one lane per cycle and then divides by the count one quotient bit per
// cycle in a restoring divider. A result that is still waiting on the rsp
// side when the next one is done holds the block until it is taken.
module logic_combine_control #(
   parameter int LANES       = lcc_pkg::LANES_DEF,
   parameter int FRAC_BITS   = lcc_pkg::FRAC_BITS_DEF,
   parameter int VALUE_WIDTH = lcc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [VALUE_WIDTH-1:0]        csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_lane [LANES],
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_value,
   output logic                          rsp_saturated
);

   localparam int W    = VALUE_WIDTH;
   localparam int LW   = $clog2(LANES + 1);
   localparam int IW   = $clog2(LANES);
   localparam int PW   = 2 * W;
   localparam int SW   = W + LW + 1;
   localparam int BW   = $clog2(SW + 1);
   localparam int MW   = $clog2(W + 1);
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  =
      (FRAC_BITS >= W - 1) ? VMAX : W'(1 << FRAC_BITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Configuration registers.
   logic [lcc_pkg::MODE_W-1:0]  mode_ff;
   logic signed [W-1:0]         thresh_ff;
   logic [lcc_pkg::COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= lcc_pkg::MODE_PASS;
         thresh_ff <= '0;
         count_ff  <= lcc_pkg::COUNT_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            lcc_pkg::CSR_MODE:      mode_ff   <= csr_data[lcc_pkg::MODE_W-1:0];
            lcc_pkg::CSR_THRESHOLD: thresh_ff <= csr_data;
            lcc_pkg::CSR_COUNT:     count_ff  <= csr_data[lcc_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective lane count, clipped to 1..LANES.
   logic [LW-1:0] n_eff;
   always_comb begin
      if (count_ff == '0) n_eff = LW'(1);
      else if (32'(count_ff) > LANES) n_eff = LW'(LANES);
      else n_eff = LW'(count_ff);
   end

   logic [2:0]          state_ff, state_in;
   logic signed [W-1:0] lane_ff [LANES];
   logic signed [W-1:0] prev_ff, held_ff;
   logic [LW-1:0]       idx_ff;
   logic [MW-1:0]       bit_ff;
   logic [W-1:0]        mplr_ff;     // multiplier bits, shifted out
   logic signed [PW-1:0] part_ff;    // partial product
   logic signed [PW-1:0] mcand_ff;   // shifted multiplicand
   logic                sat_ff;
   logic signed [SW-1:0] sum_ff;
   logic [SW-1:0]       rem_ff, quo_ff, num_ff;
   logic [BW-1:0]       dbit_ff;
   logic                neg_ff;
   logic signed [W-1:0] res_ff;
   logic                rsat_ff;
   logic                osat_ff;     // saturated flag of the waiting beat

   logic                accept;
   logic                done_go;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // A finished result moves out once the output register is free.
   assign done_go   = (state_ff == ST_DONE) && (!rsp_valid || !rsp_stall);

   // Combinational results for the simple modes.
   logic signed [W-1:0] lane0;
   logic                any_on, all_on;
   logic signed [W-1:0] quick;
   assign lane0 = req_lane[0];
   always_comb begin
      any_on = 1'b0;
      all_on = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (LW'(i) < n_eff) begin
            any_on = any_on || (req_lane[i] != '0);
            all_on = all_on && (req_lane[i] != '0);
         end
      end
      case (mode_ff)
         lcc_pkg::MODE_PASS:   quick = lane0;
         lcc_pkg::MODE_EQ:     quick = (lane0 == thresh_ff) ? ONE : '0;
         lcc_pkg::MODE_LT:     quick = (lane0 <  thresh_ff) ? ONE : '0;
         lcc_pkg::MODE_LE:     quick = (lane0 <= thresh_ff) ? ONE : '0;
         lcc_pkg::MODE_GT:     quick = (lane0 >  thresh_ff) ? ONE : '0;
         lcc_pkg::MODE_GE:     quick = (lane0 >= thresh_ff) ? ONE : '0;
         lcc_pkg::MODE_ANY:    quick = any_on ? ONE : '0;
         lcc_pkg::MODE_ALL:    quick = all_on ? ONE : '0;
         lcc_pkg::MODE_TOGGLE: quick = (prev_ff < ONE && lane0 >= ONE) ?
                                       ((held_ff >= ONE) ? '0 : ONE) : held_ff;
         default:              quick = held_ff;
      endcase
   end

   // Shift-add multiplier step and product fixup.
   logic signed [PW-1:0] part_next, shifted;
   logic                 fix_hi, fix_lo;
   assign part_next = mplr_ff[0] ? part_ff + mcand_ff : part_ff;
   assign shifted   = part_ff >>> FRAC_BITS;
   assign fix_hi    = shifted > PW'(VMAX);
   assign fix_lo    = shifted < PW'(VMIN);

   // Restoring divider step.
   logic [SW:0] trial;
   assign trial = {rem_ff, num_ff[SW-1]} - (SW+1)'(n_eff);

   logic signed [W-1:0] cur_lane;
   assign cur_lane = lane_ff[idx_ff[IW-1:0]];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            if (mode_ff == lcc_pkg::MODE_PASS && n_eff != LW'(1)) state_in = ST_MUL;
            else if (mode_ff == lcc_pkg::MODE_AVG) state_in = ST_SUM;
            else state_in = ST_DONE;
         end
         ST_MUL:  if (bit_ff == MW'(W)) state_in = ST_FIX;
         ST_FIX:  if (idx_ff == n_eff - LW'(1)) state_in = ST_DONE;
                  else state_in = ST_MUL;
         ST_SUM:  if (idx_ff == n_eff) state_in = ST_DIV;
         ST_DIV:  if (dbit_ff == BW'(SW)) state_in = ST_DONE;
         ST_DONE: if (done_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
         prev_ff   <= '0;
         held_ff   <= '0;
         osat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done_go) begin
            rsp_valid <= 1'b1;
            held_ff   <= res_ff;
            osat_ff   <= rsat_ff;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         if (accept) prev_ff <= lane0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (accept) begin
            lane_ff  <= req_lane;
            res_ff   <= quick;
            rsat_ff  <= 1'b0;
            sat_ff   <= 1'b0;
            idx_ff   <= '0;
            bit_ff   <= '0;
            mplr_ff  <= lane0;
            mcand_ff <= PW'(ONE);
            part_ff  <= '0;
            sum_ff   <= '0;
         end
         ST_MUL: begin
            if (bit_ff == MW'(W)) begin
               part_ff <= part_ff;
            end else if (bit_ff == MW'(W - 1)) begin
               // Sign bit of the multiplier weighs minus.
               part_ff <= mplr_ff[0] ? part_ff - mcand_ff : part_ff;
            end else begin
               part_ff <= part_next;
            end
            mplr_ff  <= mplr_ff >> 1;
            mcand_ff <= mcand_ff <<< 1;
            bit_ff   <= bit_ff + MW'(1);
         end
         ST_FIX: begin
            logic signed [W-1:0] p;
            logic                s;
            s = fix_hi || fix_lo;
            p = fix_hi ? VMAX : (fix_lo ? VMIN : shifted[W-1:0]);
            sat_ff   <= sat_ff || s;
            res_ff   <= p;
            rsat_ff  <= sat_ff || s;
            idx_ff   <= idx_ff + LW'(1);
            bit_ff   <= '0;
            mplr_ff  <= lane_ff[IW'(idx_ff + LW'(1))];
            mcand_ff <= PW'(p);
            part_ff  <= '0;
         end
         ST_SUM: begin
            if (idx_ff == n_eff) begin
               neg_ff  <= sum_ff[SW-1];
               num_ff  <= sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
               rem_ff  <= '0;
               quo_ff  <= '0;
               dbit_ff <= '0;
            end else begin
               sum_ff <= sum_ff + SW'(cur_lane);
               idx_ff <= idx_ff + LW'(1);
            end
         end
         ST_DIV: begin
            if (dbit_ff == BW'(SW)) begin
               res_ff <= neg_ff ? W'(-quo_ff) : quo_ff[W-1:0];
            end else begin
               if (!trial[SW]) begin
                  rem_ff <= trial[SW-1:0];
                  quo_ff <= {quo_ff[SW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[SW-2:0], num_ff[SW-1]};
                  quo_ff <= {quo_ff[SW-2:0], 1'b0};
               end
               num_ff  <= num_ff << 1;
               dbit_ff <= dbit_ff + BW'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_out_value = held_ff;
   assign rsp_saturated = osat_ff;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for logic_combine_control
// Drives lane snapshots under several mode, threshold and count settings and
// checks every output beat against a predictor or against directed table values.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NL = lcc_pkg::LANES_DEF;
   localparam int VW = lcc_pkg::VALUE_WIDTH_DEF;
   localparam int FB = lcc_pkg::FRAC_BITS_DEF;
   localparam logic signed [VW-1:0] ONE = 16'sd256;
   localparam logic signed [VW-1:0] VMAX = 16'sh7fff;
   localparam logic signed [VW-1:0] VMIN = 16'sh8000;

   typedef logic signed [VW-1:0] lanes_type [NL];
   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 sat;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = lcc_pkg::CSR_MODE;
   logic [VW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VW-1:0] req_lane [NL];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VW-1:0] rsp_out_value;
   logic rsp_saturated;

   // Predictor copy of the block's registers and state.
   logic [3:0] cfg_mode = lcc_pkg::MODE_PASS;
   logic signed [VW-1:0] cfg_thresh = '0;
   logic [3:0] cfg_count = 4'd1;
   logic signed [VW-1:0] last_lane0 = '0;
   logic signed [VW-1:0] kept_output = '0;

   outcome_type pending_outputs[$];
   int errors = 0;
   bit calm = 1'b0;      // no idling on either side
   bit hold_rsp = 1'b0;  // long receiver hold-off

   logic_combine_control u_dut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("logic_combine_control test failed");
      $finish;
   end

   task automatic report(input string what, input logic [VW-1:0] got,
                         input logic [VW-1:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Fixed-point multiply rounding toward minus infinity, then clamp.
   function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
         input logic signed [VW-1:0] b, inout logic sat);
      logic signed [2*VW-1:0] p;
      logic signed [2*VW-1:0] s;
      p = 32'(a) * 32'(b);
      s = p >>> FB;
      if (s > 32'(VMAX)) begin
         sat = 1'b1;
         return VMAX;
      end
      if (s < 32'(VMIN)) begin
         sat = 1'b1;
         return VMIN;
      end
      return s[VW-1:0];
   endfunction

   // Works out one output beat and advances the kept state.
   function automatic outcome_type combine_lanes(input lanes_type ln);
      outcome_type r;
      int n;
      logic signed [VW-1:0] p;
      logic hit;
      int sum;
      n = (cfg_count < 1) ? 1 : (cfg_count > NL) ? NL : cfg_count;
      r.sat = 1'b0;
      r.value = kept_output;
      case (cfg_mode)
         lcc_pkg::MODE_PASS: begin
            if (n == 1) r.value = ln[0];
            else begin
               p = ONE;
               for (int i = 0; i < n; i++) p = qmul(p, ln[i], r.sat);
               r.value = p;
            end
         end
         lcc_pkg::MODE_EQ: r.value = (ln[0] == cfg_thresh) ? ONE : '0;
         lcc_pkg::MODE_LT: r.value = (ln[0] < cfg_thresh) ? ONE : '0;
         lcc_pkg::MODE_LE: r.value = (ln[0] <= cfg_thresh) ? ONE : '0;
         lcc_pkg::MODE_GT: r.value = (ln[0] > cfg_thresh) ? ONE : '0;
         lcc_pkg::MODE_GE: r.value = (ln[0] >= cfg_thresh) ? ONE : '0;
         lcc_pkg::MODE_ANY: begin
            hit = 1'b0;
            for (int i = 0; i < n; i++) hit |= (ln[i] != 0);
            r.value = hit ? ONE : '0;
         end
         lcc_pkg::MODE_ALL: begin
            hit = 1'b1;
            for (int i = 0; i < n; i++) hit &= (ln[i] != 0);
            r.value = hit ? ONE : '0;
         end
         lcc_pkg::MODE_AVG: begin
            sum = 0;
            for (int i = 0; i < n; i++) sum += int'(ln[i]);
            r.value = VW'(sum / n);
         end
         lcc_pkg::MODE_TOGGLE: begin
            if (last_lane0 < ONE && ln[0] >= ONE)
               r.value = (kept_output >= ONE) ? '0 : ONE;
         end
         default: r.value = kept_output;
      endcase
      kept_output = r.value;
      last_lane0 = ln[0];
      return r;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [VW-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         lcc_pkg::CSR_MODE: cfg_mode = val[3:0];
         lcc_pkg::CSR_THRESHOLD: cfg_thresh = val;
         default: cfg_count = val[3:0];
      endcase
   endtask

   // Waits until every expected beat has come, plus the longest busy time.
   task automatic drain();
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Offers one beat, with random idle gaps, and waits for acceptance.
   task automatic send_lanes(input lanes_type ln, input bit typed,
                             input outcome_type want);
      outcome_type e;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 37) @(negedge clock);
      for (int i = 0; i < NL; i++) req_lane[i] <= ln[i];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = combine_lanes(ln);
      if (typed) e = want;
      pending_outputs.push_back(e);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [VW-1:0] rand_value();
      case ($urandom_range(5))
         0: return VW'($urandom_range(2) * 256 - 256);
         1: return VW'($urandom_range(600)) - 16'sd300;
         2: return $urandom_range(1) ? VMAX : VMIN;
         3: return '0;
         default: return VW'($urandom);
      endcase
   endfunction

   // Receiver stall process: random idling, calm stretches and one long hold.
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 37);
      end
   end

   // Output checker.
   initial begin
      outcome_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_outputs.size() == 0) report("unexpected beat", rsp_out_value, '0);
            else begin
               e = pending_outputs.pop_front();
               if (rsp_out_value !== e.value) report("out_value", rsp_out_value, e.value);
               if (rsp_saturated !== e.sat) report("saturated", 16'(rsp_saturated), 16'(e.sat));
            end
         end
      end
   end

   typedef struct {
      logic [3:0] mode;
      logic [3:0] count;
      logic signed [VW-1:0] thresh;
      logic signed [VW-1:0] l0;
      logic signed [VW-1:0] l1;
      bit typed;
      logic signed [VW-1:0] want;
      logic want_sat;
   } plan_row_type;

   plan_row_type plan [] = '{
      // Passthrough right after reset, at the extremes.
      '{lcc_pkg::MODE_PASS, 4'd1, 16'sd0, 16'sh7fff, 16'sd0, 1, 16'sh7fff, 0},
      '{lcc_pkg::MODE_PASS, 4'd1, 16'sd0, 16'sh8000, 16'sd0, 1, 16'sh8000, 0},
      // Product clamping high and low; product of two ones.
      '{lcc_pkg::MODE_PASS, 4'd2, 16'sd0, 16'sh7fff, 16'sh7fff, 1, 16'sh7fff, 1},
      '{lcc_pkg::MODE_PASS, 4'd2, 16'sd0, 16'sh7fff, 16'sh8000, 1, 16'sh8000, 1},
      '{lcc_pkg::MODE_PASS, 4'd2, 16'sd0, 16'sd256, 16'sd256, 1, 16'sd256, 0},
      '{lcc_pkg::MODE_PASS, 4'd8, 16'sd0, -16'sd3, 16'sd1, 0, 16'sd0, 0},
      // Compares, mostly against extreme thresholds, then any and all.
      '{lcc_pkg::MODE_EQ, 4'd3, 16'sh8000, 16'sh8000, 16'sd0, 1, 16'sd256, 0},
      '{lcc_pkg::MODE_LT, 4'd1, 16'sh8000, 16'sh8000, 16'sd0, 1, 16'sd0, 0},
      '{lcc_pkg::MODE_LE, 4'd1, 16'sh7fff, 16'sh7fff, 16'sd0, 1, 16'sd256, 0},
      '{lcc_pkg::MODE_GT, 4'd1, 16'sh7fff, 16'sh7fff, 16'sd0, 1, 16'sd0, 0},
      '{lcc_pkg::MODE_GE, 4'd1, -16'sd5, 16'sd7, 16'sd0, 1, 16'sd256, 0},
      '{lcc_pkg::MODE_ANY, 4'd2, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd0, 0},
      '{lcc_pkg::MODE_ALL, 4'd2, 16'sd0, 16'sd1, 16'sd1, 1, 16'sd256, 0},
      // Average truncating toward zero, and count of zero acting as one.
      '{lcc_pkg::MODE_AVG, 4'd2, 16'sd0, -16'sd3, 16'sd0, 1, -16'sd1, 0},
      '{lcc_pkg::MODE_AVG, 4'd0, 16'sd0, -16'sd9, 16'sd4, 1, -16'sd9, 0},
      '{lcc_pkg::MODE_AVG, 4'd15, 16'sd0, 16'sh7fff, 16'sh7fff, 0, 16'sd0, 0},
      // Toggle on rising edges through one, and undefined modes.
      '{lcc_pkg::MODE_TOGGLE, 4'd1, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 0},
      '{lcc_pkg::MODE_TOGGLE, 4'd1, 16'sd0, 16'sd256, 16'sd0, 0, 16'sd0, 0},
      '{lcc_pkg::MODE_TOGGLE, 4'd1, 16'sd0, 16'sd300, 16'sd0, 0, 16'sd0, 0},
      '{lcc_pkg::MODE_TOGGLE, 4'd4, 16'sd0, 16'sd255, 16'sd0, 0, 16'sd0, 0},
      '{lcc_pkg::MODE_TOGGLE, 4'd1, 16'sd0, 16'sh7fff, 16'sd0, 0, 16'sd0, 0},
      '{4'd15, 4'd1, 16'sd0, 16'sd5, 16'sd0, 0, 16'sd0, 0},
      '{4'd10, 4'd1, 16'sd0, 16'sd5, 16'sd0, 0, 16'sd0, 0}
   };

   initial begin
      lanes_type ln;
      outcome_type want;
      int phase;
      for (int i = 0; i < NL; i++) req_lane[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (plan[k]) begin
         if (k == 0 || plan[k].mode != cfg_mode || plan[k].count != cfg_count
             || plan[k].thresh != cfg_thresh) begin
            drain();
            write_reg(lcc_pkg::CSR_MODE, VW'(plan[k].mode));
            write_reg(lcc_pkg::CSR_COUNT, VW'(plan[k].count));
            write_reg(lcc_pkg::CSR_THRESHOLD, plan[k].thresh);
         end
         for (int i = 0; i < NL; i++) ln[i] = rand_value();
         ln[0] = plan[k].l0;
         ln[1] = plan[k].l1;
         want.value = plan[k].want;
         want.sat = plan[k].want_sat;
         send_lanes(ln, plan[k].typed, want);
      end

      // Random phases, each under a fresh setting.
      for (phase = 0; phase < 40; phase++) begin
         drain();
         write_reg(lcc_pkg::CSR_MODE,
                   VW'((phase < 30) ? phase % 10 : $urandom_range(15)));
         write_reg(lcc_pkg::CSR_COUNT,
                   VW'((phase % 4 == 0) ? 8 : $urandom_range(15)));
         write_reg(lcc_pkg::CSR_THRESHOLD, rand_value());
         calm = (phase == 5);
         if (phase == 7) fork
            begin
               hold_rsp = 1'b1;
               repeat (300) @(posedge clock);
               hold_rsp = 1'b0;
            end
         join_none
         for (int j = 0; j < 32; j++) begin
            for (int i = 0; i < NL; i++) ln[i] = rand_value();
            send_lanes(ln, 0, want);
         end
      end
      calm = 1'b0;

      drain();
      if (errors == 0) $display("logic_combine_control test passed");
      else $display("logic_combine_control test failed");
      $finish;
   end
endmodule
